@@ rtl/htbd_pkg.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder package
// Shared field widths, command codes and the request and node entry types.
// ----------------------------------------------------------------------------
package htbd_pkg;

   localparam int NODE_W      = 9;
   localparam int SYM_W       = 8;
   localparam int DATA_W      = 8;
   localparam int CMD_W       = 2;
   localparam int LIMIT_W     = 32;
   localparam int REQ_DATA_W  = 48;
   localparam int RSP_DATA_W  = 8;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_START  = 2'd1;
   localparam logic [CMD_W-1:0] CMD_DECODE = 2'd2;

   typedef enum logic [1:0] {
      OP_LOAD   = 2'd0,
      OP_START  = 2'd1,
      OP_DECODE = 2'd2
   } op_type;

   typedef struct packed {
      logic [NODE_W-1:0] zero_child;
      logic [NODE_W-1:0] one_child;
      logic              leaf;
      logic [SYM_W-1:0]  symbol;
   } node_entry_type;

   typedef struct packed {
      op_type            op;
      logic [NODE_W-1:0] node_index;
      node_entry_type    entry;
      logic [DATA_W-1:0] data_byte;
   } cmd_item_type;

endpackage

@@ rtl/htbd_front.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder front end
// Unpacks requests, drops those that have no effect and queues the rest.
// ----------------------------------------------------------------------------
module htbd_front #(
   parameter int NODE_COUNT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // node_index, zero_child, one_child, node_is_leaf, node_symbol, data_byte
   input  logic [htbd_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [htbd_pkg::CMD_W-1:0]    req_tuser,
   output logic                          q_valid,
   input  logic                          q_ready,
   output htbd_pkg::cmd_item_type        q_item
);
   import htbd_pkg::*;

   localparam int PTR_W = $clog2(QUEUE_DEPTH);
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

   cmd_item_type     item_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   cmd_item_type     new_item;
   logic             keep;
   logic             push;
   logic             pop;

   always_comb begin
      new_item.node_index       = req_tdata[8:0];
      new_item.entry.zero_child = req_tdata[17:9];
      new_item.entry.one_child  = req_tdata[26:18];
      new_item.entry.leaf       = req_tdata[27];
      new_item.entry.symbol     = req_tdata[35:28];
      new_item.data_byte        = req_tdata[43:36];
      new_item.op               = OP_LOAD;
      keep                      = 1'b0;
      unique case (req_tuser)
         CMD_LOAD: begin
            new_item.op = OP_LOAD;
            keep        = (32'(req_tdata[8:0]) < NODE_COUNT);
         end
         CMD_START: begin
            new_item.op = OP_START;
            keep        = 1'b1;
         end
         CMD_DECODE: begin
            new_item.op = OP_DECODE;
            keep        = 1'b1;
         end
         default: begin
            keep = 1'b0;
         end
      endcase
   end

   assign req_tready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign push       = req_tvalid && req_tready && keep;
   assign q_valid    = (count_ff != '0);
   assign pop        = q_valid && q_ready;
   assign q_item     = item_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         item_ff[wr_ptr_ff] <= new_item;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   a_count_bound : assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(QUEUE_DEPTH))
      else $error("Front queue count exceeds its depth.");

   a_push_shows : assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 && push) |=> q_valid)
      else $error("Queued request did not appear at the queue head.");

endmodule

@@ rtl/htbd_back.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder back end
// Holds the node table, walks one bit per cycle unless stalled, emits symbols.
// ----------------------------------------------------------------------------
module htbd_back #(
   parameter int NODE_COUNT = 512
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          q_valid,
   output logic                          q_ready,
   input  htbd_pkg::cmd_item_type        q_item,
   input  logic [htbd_pkg::LIMIT_W-1:0]  output_limit,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // symbol
   output logic [htbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   // last_of_run
   output logic                          rsp_tlast,
   // file_complete
   output logic                          rsp_tuser
);
   import htbd_pkg::*;

   localparam int IDX_W = $clog2(NODE_COUNT);

   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_WALK  = 3'b010,
      S_FLUSH = 3'b100
   } back_state_type;

   node_entry_type        node_mem [NODE_COUNT];

   back_state_type        state_ff, state_in;
   logic [3:0]            step_ff, step_in;
   logic [DATA_W-1:0]     byte_ff, byte_in;
   logic [IDX_W-1:0]      cur_node_ff, cur_node_in;
   logic [IDX_W-1:0]      addr_ff, addr_in;
   node_entry_type        root_ff;
   node_entry_type        rdata_ff;
   logic [LIMIT_W-1:0]    count_ff, count_in;
   logic                  pend_valid_ff, pend_valid_in;
   logic [SYM_W-1:0]      pend_sym_ff, pend_sym_in;
   logic                  pend_done_ff, pend_done_in;
   logic                  out_valid_ff, out_valid_in;
   logic [SYM_W-1:0]      out_sym_ff;
   logic                  out_last_ff;
   logic                  out_done_ff;

   logic                  out_free;
   logic                  test;
   logic                  emit;
   logic                  walk_go;
   logic                  issue;
   logic                  push;
   logic                  push_last;
   logic                  wr_en;
   logic                  rd_en;
   logic [IDX_W-1:0]      rd_addr;
   logic [LIMIT_W-1:0]    count_inc;
   node_entry_type        ent;
   logic [NODE_W-1:0]     child;
   logic [IDX_W-1:0]      next_addr;

   assign out_free  = !out_valid_ff || rsp_tready;
   assign count_inc = count_ff + 1'b1;
   assign test      = (state_ff == S_WALK) && (step_ff >= 4'd2);
   assign emit      = test && rdata_ff.leaf && (count_ff < output_limit);
   assign walk_go   = (state_ff == S_WALK) && !(emit && pend_valid_ff && !out_free);
   assign issue     = walk_go && (step_ff <= 4'd8);
   assign q_ready   = (state_ff == S_IDLE);
   assign wr_en     = (state_ff == S_IDLE) && q_valid && (q_item.op == OP_LOAD);

   always_comb begin
      ent       = (step_ff == 4'd1 || !rdata_ff.leaf) ? rdata_ff : root_ff;
      child     = byte_ff[0] ? ent.one_child : ent.zero_child;
      next_addr = (32'(child) >= NODE_COUNT) ? '0 : IDX_W'(child);
   end

   always_comb begin
      state_in      = state_ff;
      step_in       = step_ff;
      byte_in       = byte_ff;
      cur_node_in   = cur_node_ff;
      addr_in       = addr_ff;
      count_in      = count_ff;
      pend_valid_in = pend_valid_ff;
      pend_sym_in   = pend_sym_ff;
      pend_done_in  = pend_done_ff;
      push          = 1'b0;
      push_last     = 1'b0;
      rd_en         = 1'b0;
      rd_addr       = next_addr;
      unique case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               unique case (q_item.op)
                  OP_START: begin
                     cur_node_in = '0;
                     count_in    = '0;
                  end
                  OP_DECODE: begin
                     rd_en    = 1'b1;
                     rd_addr  = cur_node_ff;
                     byte_in  = q_item.data_byte;
                     step_in  = 4'd1;
                     state_in = S_WALK;
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_WALK: begin
            if (walk_go) begin
               if (test) begin
                  cur_node_in = rdata_ff.leaf ? '0 : addr_ff;
               end
               if (emit) begin
                  push          = pend_valid_ff;
                  count_in      = count_inc;
                  pend_valid_in = 1'b1;
                  pend_sym_in   = rdata_ff.symbol;
                  pend_done_in  = (count_inc == output_limit);
               end
               if (issue) begin
                  rd_en   = 1'b1;
                  addr_in = next_addr;
                  byte_in = byte_ff >> 1;
               end
               step_in = step_ff + 1'b1;
               if (step_ff == 4'd9) begin
                  state_in = S_FLUSH;
               end
            end
         end
         S_FLUSH: begin
            if (!pend_valid_ff) begin
               state_in = S_IDLE;
            end else if (out_free) begin
               push          = 1'b1;
               push_last     = 1'b1;
               pend_valid_in = 1'b0;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign out_valid_in = push || (out_valid_ff && !rsp_tready);

   always_ff @(posedge clock) begin
      if (wr_en) begin
         node_mem[IDX_W'(q_item.node_index)] <= q_item.entry;
      end
      if (rd_en) begin
         rdata_ff <= node_mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && q_item.node_index == '0) begin
         root_ff <= q_item.entry;
      end
      if (push) begin
         out_sym_ff  <= pend_sym_ff;
         out_last_ff <= push_last;
         out_done_ff <= pend_done_ff;
      end
      byte_ff     <= byte_in;
      addr_ff     <= addr_in;
      pend_sym_ff <= pend_sym_in;
      pend_done_ff <= pend_done_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         step_ff       <= '0;
         cur_node_ff   <= '0;
         count_ff      <= '0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         step_ff       <= step_in;
         cur_node_ff   <= cur_node_in;
         count_ff      <= count_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_sym_ff;
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_done_ff;

   a_idle_no_pending : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_IDLE |-> !pend_valid_ff)
      else $error("A symbol is still pending while the walker is idle.");

   a_step_range : assert property (@(posedge clock) disable iff (reset)
      state_ff == S_WALK |-> (step_ff >= 4'd1 && step_ff <= 4'd9))
      else $error("Walk step counter left its range.");

   a_rsp_source : assert property (@(posedge clock) disable iff (reset)
      $rose(out_valid_ff) |-> ($past(state_ff) == S_WALK || $past(state_ff) == S_FLUSH))
      else $error("Response raised outside a walk or flush.");

endmodule

@@ rtl/huffman_tree_bit_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder
// Loads a code tree into a node table and decodes coded bytes into symbols.
//
//   Port group   Direction  Content
//   req_         in         tuser: cmd; tdata: node fields and coded byte
//   rsp_         out        tdata: symbol; tlast: last_of_run;
//                           tuser: file_complete
//   csr_         in         output_limit write
//
// A load or start request is taken by the back end while it idles. A decode
// request makes one node table read to fetch the current node, eight
// dependent reads through the single read port of the node table and a last
// leaf test, then releases the last symbol, if any, with its end mark.
// Reset clears the walk state, the symbol count and the output limit; the
// node table is not cleared. A stalled response holds the walk only when a
// second symbol is ready; up to two requests queue in front meanwhile.
// ----------------------------------------------------------------------------
module huffman_tree_bit_decoder_top #(
   parameter int NODE_COUNT = 512
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   // node_index, zero_child, one_child, node_is_leaf, node_symbol, data_byte
   input  logic [htbd_pkg::REQ_DATA_W-1:0] req_tdata,
   // cmd
   input  logic [htbd_pkg::CMD_W-1:0]     req_tuser,
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   // symbol
   output logic [htbd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic                           rsp_tlast,
   // file_complete
   output logic                           rsp_tuser,
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [htbd_pkg::LIMIT_W-1:0]   csr_wdata
);
   import htbd_pkg::*;

   logic               q_valid;
   logic               q_ready;
   cmd_item_type       q_item;
   logic [LIMIT_W-1:0] limit_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         limit_ff <= csr_wdata;
      end
   end

   htbd_front #(
      .NODE_COUNT (NODE_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .q_valid    (q_valid),
      .q_ready    (q_ready),
      .q_item     (q_item)
   );

   htbd_back #(
      .NODE_COUNT (NODE_COUNT)
   ) u_back (
      .clock        (clock),
      .reset        (reset),
      .q_valid      (q_valid),
      .q_ready      (q_ready),
      .q_item       (q_item),
      .output_limit (limit_ff),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tlast    (rsp_tlast),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

@@ verif/tb_huffman_tree_bit_decoder_top.sv @@
// ----------------------------------------------------------------------------
// Huffman tree bit decoder testbench
// Loads code trees into the node table, then streams requests of every kind
// with random gaps on both sides. A predictor walks its own copy of
// the node table, and every response is compared with the oldest expected
// symbol. The output limit is changed between phases while the block idles.
// ----------------------------------------------------------------------------
module tb_huffman_tree_bit_decoder_top;
   import htbd_pkg::*;

   localparam int NODES = 512;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_CYCLES = 40;
   localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   typedef struct {
      logic [CMD_W-1:0]  cmd;
      logic [NODE_W-1:0] node_index;
      logic [NODE_W-1:0] zero_child;
      logic [NODE_W-1:0] one_child;
      logic              leaf;
      logic [SYM_W-1:0]  node_symbol;
      logic [DATA_W-1:0] data_byte;
   } req_item_type;

   typedef struct {
      logic [SYM_W-1:0] symbol;
      logic             last;
      logic             complete;
   } sym_result_type;

   logic clock;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [REQ_DATA_W-1:0] req_tdata = '0;
   logic [CMD_W-1:0] req_tuser = '0;
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic rsp_tlast;
   logic rsp_tuser;
   logic csr_valid = 1'b0;
   logic csr_ready;
   logic [LIMIT_W-1:0] csr_wdata = '0;

   huffman_tree_bit_decoder_top #(.NODE_COUNT(NODES)) uut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_wdata(csr_wdata)
   );

   node_entry_type    tree_mem [NODES];
   logic [NODE_W-1:0] walk_node = '0;
   logic [31:0]       symbol_count = '0;
   logic [31:0]       out_limit = '0;
   sym_result_type    symbol_queue [$];

   req_item_type  pending_reqs [$];
   req_item_type  cur_req;
   bit            req_busy = 1'b0;
   idle_mode_type idle_mode = IDLE_NONE;
   bit            node_loaded [NODES];
   int            loaded_list [$];
   int            random_count = 0;
   int            fail_count = 0;
   int            cycle_count = 0;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   task automatic predict_symbols(input req_item_type it);
      logic [NODE_W-1:0] nxt;
      sym_result_type    res;
      sym_result_type    batch [$];
      case (it.cmd)
         OP_LOAD: begin
            tree_mem[it.node_index] = {it.zero_child, it.one_child, it.leaf, it.node_symbol};
         end
         OP_START: begin
            walk_node = '0;
            symbol_count = '0;
         end
         OP_DECODE: begin
            for (int b = 0; b < DATA_W; b++) begin
               nxt = it.data_byte[b] ? tree_mem[walk_node].one_child
                                     : tree_mem[walk_node].zero_child;
               if (tree_mem[nxt].leaf) begin
                  if (symbol_count < out_limit) begin
                     symbol_count = symbol_count + 1;
                     res.symbol = tree_mem[nxt].symbol;
                     res.last = 1'b0;
                     res.complete = (symbol_count == out_limit);
                     batch.push_back(res);
                  end
                  walk_node = '0;
               end else begin
                  walk_node = nxt;
               end
            end
            if (batch.size() > 0) begin
               batch[batch.size()-1].last = 1'b1;
            end
            foreach (batch[i]) symbol_queue.push_back(batch[i]);
         end
         default: begin
         end
      endcase
   endtask

   function automatic bit sender_idles();
      if (idle_mode == IDLE_SENDER) return $urandom_range(0, 99) < 56;
      if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 34;
      return 1'b0;
   endfunction

   function automatic bit receiver_stalls();
      if (idle_mode == IDLE_RECEIVER) return $urandom_range(0, 99) < 56;
      if (idle_mode == IDLE_BOTH) return $urandom_range(0, 99) < 34;
      return 1'b0;
   endfunction

   always @(negedge clock) begin
      if (!reset) begin
         if (!req_busy) begin
            if (pending_reqs.size() > 0 && !sender_idles()) begin
               cur_req = pending_reqs.pop_front();
               req_tdata <= {4'd0, cur_req.data_byte, cur_req.node_symbol, cur_req.leaf,
                             cur_req.one_child, cur_req.zero_child, cur_req.node_index};
               req_tuser <= cur_req.cmd;
               req_tvalid <= 1'b1;
               req_busy = 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
         rsp_tready <= !receiver_stalls();
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("FAIL huffman_tree_bit_decoder_top");
         $finish;
      end
      if (!reset) begin
         if (req_tvalid && req_tready) begin
            predict_symbols(cur_req);
            req_busy = 1'b0;
         end
         if (rsp_tvalid && rsp_tready) begin
            if (symbol_queue.size() == 0) begin
               $display("%0t: unexpected response: expected none, actual sym %h last %b done %b",
                        $time, rsp_tdata, rsp_tlast, rsp_tuser);
               fail_count++;
            end else begin
               automatic sym_result_type exp_res = symbol_queue.pop_front();
               if (rsp_tdata !== exp_res.symbol || rsp_tlast !== exp_res.last ||
                   rsp_tuser !== exp_res.complete) begin
                  $display({"%0t: mismatch: expected sym %h last %b done %b, ",
                            "actual sym %h last %b done %b"},
                           $time, exp_res.symbol, exp_res.last, exp_res.complete,
                           rsp_tdata, rsp_tlast, rsp_tuser);
                  fail_count++;
               end
            end
         end
      end
   end

   function automatic req_item_type random_item(input logic [CMD_W-1:0] cmd);
      req_item_type it;
      it.cmd = cmd;
      it.node_index = NODE_W'($urandom);
      it.zero_child = NODE_W'($urandom);
      it.one_child = NODE_W'($urandom);
      it.leaf = 1'($urandom);
      it.node_symbol = SYM_W'($urandom);
      it.data_byte = DATA_W'($urandom);
      return it;
   endfunction

   task automatic queue_load(input int idx, input int c0, input int c1,
                             input bit leaf, input logic [SYM_W-1:0] sym);
      req_item_type it;
      it = random_item(OP_LOAD);
      it.node_index = NODE_W'(idx);
      it.zero_child = NODE_W'(c0);
      it.one_child = NODE_W'(c1);
      it.leaf = leaf;
      it.node_symbol = sym;
      if (!node_loaded[idx]) begin
         node_loaded[idx] = 1'b1;
         loaded_list.push_back(idx);
      end
      pending_reqs.push_back(it);
   endtask

   task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] byte_val);
      req_item_type it;
      it = random_item(cmd);
      it.data_byte = byte_val;
      pending_reqs.push_back(it);
   endtask

   function automatic int pick_loaded();
      return loaded_list[$urandom_range(0, loaded_list.size() - 1)];
   endfunction

   // Grows a random full tree from the root by splitting leaves, then loads
   // it newest node first, so each child is in the table before its parent.
   task automatic grow_code_tree();
      int pos_idx [32];
      int pos_c0 [32];
      int pos_c1 [32];
      bit pos_leaf [32];
      bit used [NODES];
      int n;
      int p;
      int cand;
      int leaves;
      n = 1;
      pos_idx[0] = 0;
      pos_leaf[0] = 1'b1;
      used[0] = 1'b1;
      leaves = $urandom_range(1, 10);
      for (int k = 1; k < leaves; k++) begin
         do p = $urandom_range(0, n - 1); while (!pos_leaf[p]);
         pos_leaf[p] = 1'b0;
         for (int c = 0; c < 2; c++) begin
            do cand = $urandom_range(1, NODES - 1); while (used[cand]);
            used[cand] = 1'b1;
            pos_idx[n] = cand;
            pos_leaf[n] = 1'b1;
            if (c == 0) pos_c0[p] = n;
            else pos_c1[p] = n;
            n++;
         end
      end
      for (int q = n - 1; q >= 0; q--) begin
         if (pos_leaf[q]) begin
            queue_load(pos_idx[q], pick_loaded(), pick_loaded(), 1'b1, SYM_W'($urandom));
         end else begin
            queue_load(pos_idx[q], pos_idx[pos_c0[q]], pos_idx[pos_c1[q]], 1'b0,
                       SYM_W'($urandom));
         end
         random_count++;
      end
   endtask

   task automatic wait_idle();
      do @(negedge clock);
      while (pending_reqs.size() > 0 || req_busy || symbol_queue.size() > 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_limit(input logic [LIMIT_W-1:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      out_limit = value;
      @(negedge clock);
      csr_valid <= 1'b0;
      csr_wdata <= $urandom;
      @(posedge clock);
   endtask

   initial begin
      int pick;
      int phase;
      logic [LIMIT_W-1:0] limit_val;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: field extremes, a self loop, a full byte of symbols,
      // a byte with none, the unused command and a start in mid walk.
      write_limit(32'hFFFF_FFFF);
      queue_load(1, 0, 0, 1'b1, 8'h00);
      queue_load(2, 1, 1, 1'b1, 8'hFF);
      queue_load(511, 2, 511, 1'b0, 8'h3C);
      queue_load(1, 511, 511, 1'b1, 8'h00);
      queue_load(0, 1, 511, 1'b0, 8'hC3);
      queue_cmd(OP_DECODE, 8'h00);
      queue_cmd(OP_DECODE, 8'hFF);
      queue_cmd(OP_DECODE, 8'h00);
      queue_cmd(OP_DECODE, 8'h55);
      queue_cmd(OP_DECODE, 8'hAA);
      queue_cmd(CMD_UNUSED, 8'h00);
      queue_cmd(OP_DECODE, 8'hFF);
      queue_cmd(OP_START, 8'hFF);
      queue_cmd(OP_DECODE, 8'h00);
      // The root itself as a leaf gives a symbol on every bit.
      queue_load(0, 0, 0, 1'b1, 8'h5A);
      queue_cmd(OP_DECODE, 8'hC3);
      wait_idle();

      // Directed: the limit is reached inside a byte and later symbols are
      // dropped until the next start.
      write_limit(32'd3);
      queue_load(0, 1, 511, 1'b0, 8'h81);
      queue_cmd(OP_START, 8'h00);
      queue_cmd(OP_DECODE, 8'h00);
      queue_cmd(OP_DECODE, 8'h00);
      queue_cmd(OP_START, 8'h00);
      queue_cmd(OP_DECODE, 8'hAA);
      queue_cmd(OP_DECODE, 8'h00);

      phase = 0;
      while (random_count < 170) begin
         wait_idle();
         pick = $urandom_range(0, 9);
         if (phase == 0 || pick == 0) limit_val = 32'd0;
         else if (phase == 1 || pick == 1) limit_val = 32'hFFFF_FFFF;
         else limit_val = $urandom_range(1, 24);
         write_limit(limit_val);
         idle_mode = idle_mode_type'(phase % 4);
         if ($urandom_range(0, 9) < 8) grow_code_tree();
         queue_cmd(OP_START, DATA_W'($urandom));
         for (int k = 0; k < 28; k++) begin
            pick = $urandom_range(0, 99);
            if (pick < 70) begin
               queue_cmd(OP_DECODE, DATA_W'($urandom));
            end else if (pick < 78) begin
               queue_cmd(OP_START, DATA_W'($urandom));
            end else if (pick < 86) begin
               queue_load($urandom_range(0, NODES - 1), pick_loaded(), pick_loaded(),
                          1'($urandom), SYM_W'($urandom));
            end else if (pick < 92) begin
               queue_cmd(CMD_UNUSED, DATA_W'($urandom));
               random_count--;
            end else begin
               queue_cmd(OP_DECODE, $urandom_range(0, 1) ? 8'hFF : 8'h00);
            end
            random_count++;
         end
         phase++;
      end

      wait_idle();
      if (symbol_queue.size() != 0) begin
         $display("%0t: %0d expected symbols never arrived", $time, symbol_queue.size());
         fail_count++;
      end
      if (fail_count == 0) begin
         $display("PASS huffman_tree_bit_decoder_top");
      end else begin
         $display("FAIL huffman_tree_bit_decoder_top");
      end
      $finish;
   end

endmodule
